// ===== rtl/i2c_master_bit_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

// expression holds at every edge outside reset
`define I2CM_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("i2cm assertion failed");

// consequent holds in the cycle after the antecedent
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cm assertion failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int HALF_W      = 16;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	// register index, taken from paddr[2]
	localparam logic REG_HALF_PERIOD = 1'b0;
	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(250);

	// command codes on the mode field
	localparam logic [2:0] MODE_START = 3'd0;
	localparam logic [2:0] MODE_STOP  = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_READ  = 3'd3;
	localparam logic [2:0] MODE_ACK   = 3'd4;

	localparam logic [3:0] WRITE_BITS = 4'd9;  // eight data bits plus ACK slot
	localparam logic [3:0] READ_BITS  = 4'd8;
	localparam logic [3:0] ACK_BITS   = 4'd1;
	localparam logic [3:0] DATA_BITS  = 4'd8;

	typedef enum logic [5:0] {
		OP_IDLE  = 6'b000001,
		OP_START = 6'b000010,
		OP_STOP  = 6'b000100,
		OP_WRITE = 6'b001000,
		OP_READ  = 6'b010000,
		OP_ACK   = 6'b100000
	} op_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] mode;
		logic [7:0] write_byte;
		logic       ack_level;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_seen;
	} res_item_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_cmd_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_cmd_if
// Valid/ready channel carrying one input tick item.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_cmd_if import i2cm_pkg::*;;
	logic      valid;
	logic      ready;
	cmd_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_res_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_res_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_res_if import i2cm_pkg::*;;
	logic      valid;
	logic      ready;
	res_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// i2cm_apb_regs
// APB register bank holding the SCL half period.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_apb_regs import i2cm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [HALF_W-1:0] half_period
);

	logic [HALF_W-1:0] half_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RST;
		end else if (wr_en) begin
			half_q <= pwdata[HALF_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF_PERIOD: prdata = APB_DW'(half_q);
			default:         prdata = '0;
		endcase
	end

	assign half_period = half_q;

endmodule

`default_nettype wire

// ===== rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus state and per-tick next-state logic of the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire cmd_item_t         item,
	input  wire logic [HALF_W-1:0] half_period,
	output res_item_t              res
);

	localparam int CW = (TIMER_WIDTH > HALF_W) ? TIMER_WIDTH : HALF_W;
	localparam logic [CW-1:0] TIMER_MAX = CW'({TIMER_WIDTH{1'b1}});

	op_t                    op_q, op_n;
	logic [1:0]             phase_q, phase_n;
	logic [3:0]             bit_cnt_q, bit_cnt_n;
	logic [7:0]             shift_q, shift_n;
	logic [TIMER_WIDTH-1:0] timer_q, timer_n, timer_dec;
	logic                   scl_q, scl_n;
	logic                   sda_q, sda_n;
	logic [7:0]             rd_q, rd_n;
	logic                   ack_q, ack_n;
	logic                   done;
	logic                   ended;
	logic [3:0]             last;
	logic [CW-1:0]          h_ext;
	logic [TIMER_WIDTH-1:0] seg_len;

	// SDA during the low half of a bit
	function automatic logic low_half_sda(op_t op, logic [3:0] bc, logic [7:0] sh);
		logic drive;
		drive = ((op == OP_WRITE) && (bc < DATA_BITS)) || (op == OP_ACK);
		return drive ? sh[7] : 1'b1;
	endfunction

	always_comb begin
		h_ext = CW'(half_period);
		if (h_ext == '0) begin
			h_ext = CW'(1);
		end
		if (h_ext > TIMER_MAX) begin
			h_ext = TIMER_MAX;
		end
		seg_len = h_ext[TIMER_WIDTH-1:0];
	end

	assign timer_dec = timer_q - TIMER_WIDTH'(1);

	always_comb begin
		op_n      = op_q;
		phase_n   = phase_q;
		bit_cnt_n = bit_cnt_q;
		shift_n   = shift_q;
		timer_n   = timer_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		rd_n      = rd_q;
		ack_n     = ack_q;
		done      = 1'b0;
		ended     = 1'b0;
		last      = ACK_BITS;

		if (op_q == OP_IDLE) begin
			if (item.cmd_valid && (item.mode <= MODE_ACK)) begin
				phase_n   = 2'd0;
				bit_cnt_n = 4'd0;
				unique case (item.mode)
					MODE_START: begin
						op_n  = OP_START;
						sda_n = 1'b1;
					end
					MODE_STOP: begin
						op_n  = OP_STOP;
						sda_n = 1'b0;
					end
					MODE_WRITE: begin
						op_n    = OP_WRITE;
						shift_n = item.write_byte;
						scl_n   = 1'b0;
						sda_n   = item.write_byte[7];
					end
					MODE_READ: begin
						op_n    = OP_READ;
						shift_n = 8'd0;
						scl_n   = 1'b0;
						sda_n   = 1'b1;
					end
					default: begin
						op_n    = OP_ACK;
						shift_n = {item.ack_level, 7'd0};
						scl_n   = 1'b0;
						sda_n   = item.ack_level;
					end
				endcase
				timer_n = seg_len;
			end
		end else begin
			timer_n = timer_dec;
			if (timer_dec == '0) begin
				if ((op_q == OP_START) || (op_q == OP_STOP)) begin
					phase_n = phase_q + 2'd1;
					if (phase_n == 2'd1) begin
						scl_n = 1'b1;
					end else if (phase_n == 2'd2) begin
						sda_n = (op_q == OP_START) ? 1'b0 : 1'b1;
					end else begin
						if (op_q == OP_START) begin
							scl_n = 1'b0;
						end
						ended = 1'b1;
					end
				end else if (phase_q == 2'd0) begin
					phase_n = 2'd1;
					scl_n   = 1'b1;
				end else begin
					if (op_q == OP_WRITE) begin
						if (bit_cnt_q >= DATA_BITS) begin
							ack_n = item.sda_in;
						end else begin
							shift_n = {shift_q[6:0], 1'b0};
						end
						last = WRITE_BITS;
					end else if (op_q == OP_READ) begin
						shift_n = {shift_q[6:0], item.sda_in};
						last    = READ_BITS;
					end
					bit_cnt_n = bit_cnt_q + 4'd1;
					if (bit_cnt_n >= last) begin
						scl_n = 1'b0;
						if (op_q == OP_READ) begin
							rd_n = shift_n;
						end
						ended = 1'b1;
					end else begin
						phase_n = 2'd0;
						scl_n   = 1'b0;
						sda_n   = low_half_sda(op_q, bit_cnt_n, shift_n);
					end
				end
				if (ended) begin
					op_n      = OP_IDLE;
					phase_n   = 2'd0;
					bit_cnt_n = 4'd0;
					timer_n   = '0;
					done      = 1'b1;
				end else begin
					timer_n = seg_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_IDLE;
			phase_q   <= 2'd0;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'd0;
			timer_q   <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			rd_q      <= 8'd0;
			ack_q     <= 1'b1;
		end else if (step) begin
			op_q      <= op_n;
			phase_q   <= phase_n;
			bit_cnt_q <= bit_cnt_n;
			shift_q   <= shift_n;
			timer_q   <= timer_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			rd_q      <= rd_n;
			ack_q     <= ack_n;
		end
	end

	// result of this tick, shown after the update
	always_comb begin
		res.scl_drive = scl_n;
		res.sda_drive = sda_n;
		res.busy_res  = (op_n != OP_IDLE);
		res.done_res  = done;
		res.read_byte = rd_n;
		res.ack_seen  = ack_n;
	end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine_top.sv =====
// Path: a tick item accepted into the input register steps through the engine, and
// its result item is held in the result register until it is taken.
// Throughput: one tick item per cycle unless a result that is not taken stalls the step;
// the input register and the result register let a new item in while a finished result waits to be taken.
// Reset: arst_n clears both stages, the bus state (SCL/SDA released, idle)
// and sets the half period register to 250.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: APB config, input register, engine, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_top import i2cm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	i2cm_cmd_if.sink               cmd,
	i2cm_res_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic              in_valid_s1;
	cmd_item_t         in_item_s1;
	logic              out_valid_s2;
	res_item_t         out_item_s2;
	res_item_t         res_next;
	logic              step;
	logic [HALF_W-1:0] half_period;

	i2cm_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.half_period (half_period)
	);

	// item in stage 1 moves on when the result register is free or draining
	assign step      = in_valid_s1 && (!out_valid_s2 || res.ready);
	assign cmd.ready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			in_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			in_item_s1 <= cmd.payload;
		end
	end

	i2cm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (in_item_s1),
		.half_period (half_period),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step) begin
			out_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_item_s2 <= res_next;
		end
	end

	assign res.valid   = out_valid_s2;
	assign res.payload = out_item_s2;

endmodule

`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the bit engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_engine_top_assert.svh"

module i2cm_checker import i2cm_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire res_item_t         res_payload,
	input wire logic              pready,
	input wire logic [APB_DW-1:0] prdata
);

	// stalled result stays put
	`I2CM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload))

	// the finishing tick already reports idle
	`I2CM_ASSERT_ALWAYS(a_done_not_busy, clk, arst_n, !(res_valid && res_payload.done_res && res_payload.busy_res))

	`I2CM_ASSERT_ALWAYS(a_pready_high, clk, arst_n, pready)

	// only the 16-bit half period is readable
	`I2CM_ASSERT_ALWAYS(a_prdata_upper, clk, arst_n, prdata[APB_DW-1:HALF_W] == '0)

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload),
	.pready      (pready),
	.prdata      (prdata)
);

`default_nettype wire
